// ----- sv/json_string_escaper_unit_macros.svh -----
// Assertion macros for the JSON string escaper.
`ifndef JSON_STRING_ESCAPER_UNIT_MACROS_SVH
`define JSON_STRING_ESCAPER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked out of reset
`define JSE_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");

// Next-cycle implication, checked out of reset
`define JSE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`else

`define JSE_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define JSE_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- sv/jse_pkg.sv -----
package jse_pkg;

   // descriptor geometry: up to eight bytes per item
   localparam int MaxBytes   = 8;
   localparam int IndexWidth = 3;
   localparam int CountWidth = 4;
   localparam int BodyWidth  = 3;

   // queue geometry
   localparam int QueueDepth = 2;
   localparam int PtrWidth   = 1;
   localparam int FillWidth  = 2;

   // characters
   localparam logic [7:0] QuoteChar     = 8'h22;
   localparam logic [7:0] BackslashChar = 8'h5C;
   localparam logic [7:0] SlashChar     = 8'h2F;
   localparam logic [7:0] BackspaceChar = 8'h08;
   localparam logic [7:0] FormfeedChar  = 8'h0C;
   localparam logic [7:0] NewlineChar   = 8'h0A;
   localparam logic [7:0] ReturnChar    = 8'h0D;
   localparam logic [7:0] TabChar       = 8'h09;
   localparam logic [7:0] DeleteChar    = 8'h7F;
   localparam logic [7:0] SpaceChar     = 8'h20;
   localparam logic [7:0] LetterB       = 8'h62;
   localparam logic [7:0] LetterF       = 8'h66;
   localparam logic [7:0] LetterN       = 8'h6E;
   localparam logic [7:0] LetterR       = 8'h72;
   localparam logic [7:0] LetterT       = 8'h74;
   localparam logic [7:0] LetterU       = 8'h75;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        first_unit;
      logic        last_unit;
      logic        empty_string;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_byte;
   } rsp_type;

   // bytes to emit, byte 0 first, and the index of the final one
   typedef struct packed {
      logic [MaxBytes-1:0][7:0] byte_list;
      logic [IndexWidth-1:0]    last_index;
   } desc_type;

   typedef struct packed {
      logic head_valid;
      logic full;
   } queue_status_type;

   // uppercase hex digit for one nibble
   function automatic logic [7:0] hex_char(input logic [3:0] nibble);
      logic [7:0] code;
      if (nibble < 4'd10) begin
         code = 8'h30 + {4'd0, nibble};
      end else begin
         code = 8'h37 + {4'd0, nibble};
      end
      return code;
   endfunction

endpackage

// ----- sv/jse_front.sv -----
module jse_front import jse_pkg::*; (
   input  logic     req_valid,
   output logic     req_stall,
   input  req_type  req_data,
   input  logic     queue_full,
   output logic     push,
   output desc_type push_desc
);

   logic [MaxBytes*8-1:0] body_bits;
   logic [MaxBytes*8-1:0] list_bits;
   logic [BodyWidth-1:0]  body_count;
   logic [IndexWidth-1:0] close_pos;
   logic [CountWidth-1:0] total;
   logic [CountWidth-1:0] total_less;
   logic [7:0]            low_byte;

   assign low_byte = req_data.code_unit[7:0];

   // classify the unit into its escape body
   always_comb begin
      body_bits  = '0;
      body_count = '0;
      if (req_data.code_unit[15:8] != 8'd0) begin
         body_bits[7:0]   = BackslashChar;
         body_bits[15:8]  = LetterU;
         body_bits[23:16] = hex_char(req_data.code_unit[15:12]);
         body_bits[31:24] = hex_char(req_data.code_unit[11:8]);
         body_bits[39:32] = hex_char(req_data.code_unit[7:4]);
         body_bits[47:40] = hex_char(req_data.code_unit[3:0]);
         body_count       = BodyWidth'(6);
      end else begin
         case (low_byte)
            QuoteChar, BackslashChar, SlashChar: begin
               body_bits[7:0]  = BackslashChar;
               body_bits[15:8] = low_byte;
               body_count      = BodyWidth'(2);
            end
            BackspaceChar: begin
               body_bits[15:0] = {LetterB, BackslashChar};
               body_count      = BodyWidth'(2);
            end
            FormfeedChar: begin
               body_bits[15:0] = {LetterF, BackslashChar};
               body_count      = BodyWidth'(2);
            end
            NewlineChar: begin
               body_bits[15:0] = {LetterN, BackslashChar};
               body_count      = BodyWidth'(2);
            end
            ReturnChar: begin
               body_bits[15:0] = {LetterR, BackslashChar};
               body_count      = BodyWidth'(2);
            end
            TabChar: begin
               body_bits[15:0] = {LetterT, BackslashChar};
               body_count      = BodyWidth'(2);
            end
            default: begin
               // drop the remaining control characters
               if (low_byte < SpaceChar || low_byte == DeleteChar) begin
                  body_count = '0;
               end else begin
                  body_bits[7:0] = low_byte;
                  body_count     = BodyWidth'(1);
               end
            end
         endcase
      end
   end

   // wrap the body in the quotes that the marks ask for
   always_comb begin
      list_bits = '0;
      total     = '0;
      close_pos = '0;
      if (req_data.empty_string) begin
         list_bits[15:0] = {QuoteChar, QuoteChar};
         total           = CountWidth'(2);
      end else begin
         if (req_data.first_unit) begin
            list_bits = {body_bits[MaxBytes*8-9:0], QuoteChar};
         end else begin
            list_bits = body_bits;
         end
         close_pos = IndexWidth'(body_count) + IndexWidth'(req_data.first_unit);
         if (req_data.last_unit) begin
            list_bits[close_pos*8 +: 8] = QuoteChar;
         end
         total = CountWidth'(body_count) + CountWidth'(req_data.first_unit)
               + CountWidth'(req_data.last_unit);
      end
   end

   assign total_less = total - CountWidth'(1);

   // hand over every transfer that yields bytes; drop the rest here
   assign req_stall            = queue_full;
   assign push                 = req_valid && !queue_full && (total != '0);
   assign push_desc.byte_list  = list_bits;
   assign push_desc.last_index = total_less[IndexWidth-1:0];

endmodule

// ----- sv/jse_queue.sv -----
module jse_queue import jse_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  desc_type         push_desc,
   input  logic             pop,
   output queue_status_type status,
   output desc_type         head_desc
);

   desc_type              entry_ff [QueueDepth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FillWidth-1:0]  fill_ff, fill_in;

   // advance pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + PtrWidth'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + PtrWidth'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + FillWidth'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - FillWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // store the pushed descriptor
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   assign head_desc         = entry_ff[rd_ptr_ff];
   assign status.head_valid = (fill_ff != '0);
   assign status.full       = (fill_ff == FillWidth'(QueueDepth));

endmodule

// ----- sv/jse_back.sv -----
module jse_back import jse_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type status,
   input  desc_type         head_desc,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data
);

   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;
   logic [IndexWidth-1:0] index_ff, index_in;
   logic                  out_free;
   logic                  at_end;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign at_end   = (index_ff == head_desc.last_index);

   // step through the head descriptor one byte per free output slot
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      index_in     = index_ff;
      pop          = 1'b0;
      if (out_free) begin
         rsp_valid_in = status.head_valid;
         if (status.head_valid) begin
            rsp_data_in.out_byte  = head_desc.byte_list[index_ff];
            rsp_data_in.last_byte = at_end;
            if (at_end) begin
               index_in = '0;
               pop      = 1'b1;
            end else begin
               index_in = index_ff + IndexWidth'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         index_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         index_ff     <= index_in;
      end
   end

   // hold the payload while the output waits
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- sv/json_string_escaper_unit.sv -----
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_stall  req_data : code_unit, first/last, empty mark
// rsp       out        rsp_valid / rsp_stall  rsp_data : out_byte, last_byte
//
// One result byte leaves per cycle from the output register unless rsp_stall holds it;
// an item yields 1 to 8 bytes, stepped out by the back end's byte sequencer.
// A unit that yields no byte is dropped by the front end and never reaches the back end.
// First byte of an item passes through the descriptor queue and then the output register.
// Reset clears the two-entry descriptor queue, the byte index and the output valid.
// req_stall rises only while the queue is full; rsp_stall holds the output register.
`include "json_string_escaper_unit_macros.svh"

module json_string_escaper_unit import jse_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic             push;
   logic             pop;
   logic             req_fire;
   desc_type         push_desc;
   desc_type         head_desc;
   queue_status_type status;

   // classify each transfer into a descriptor
   jse_front u_front (
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .queue_full (status.full),
      .push       (push),
      .push_desc  (push_desc)
   );

   // decouple the two sides
   jse_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .status    (status),
      .head_desc (head_desc)
   );

   // emit the bytes
   jse_back u_back (
      .clock     (clock),
      .reset     (reset),
      .status    (status),
      .head_desc (head_desc),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // input transfer
   assign req_fire = req_valid && !req_stall;

   `JSE_ASSERT_IMPLY(full_has_head, clock, reset, status.full, status.head_valid)
   `JSE_ASSERT_IMPLY(pop_needs_head, clock, reset, pop, status.head_valid)
   `JSE_ASSERT_NEXT(empty_string_queued, clock, reset, req_fire && req_data.empty_string, status.head_valid)
   `JSE_ASSERT_NEXT(result_from_head, clock, reset, !rsp_valid && !status.head_valid, !rsp_valid)

endmodule

// ----- tb/sv/json_string_escaper_unit_tb.sv -----
`timescale 1ns / 1ps

module json_string_escaper_unit_tb import jse_pkg::*; ();

   // cycles without any transfer before the run is abandoned
   localparam int StallLimit   = 1000;
   localparam int RandomUnits  = 200;
   localparam int CalmUnits    = 170;
   localparam int ReportLimit  = 10;
   localparam int DrainCycles  = 12;

   // Expected byte stream of the escaper and its checker
   class escape_scoreboard;
      rsp_type expected_bytes[$];
      int      fault_count;

      function rsp_type plain_byte(logic [7:0] b);
         rsp_type r;
         r.out_byte  = b;
         r.last_byte = 1'b0;
         return r;
      endfunction

      // uppercase hex digit of one nibble
      function logic [7:0] hex_digit(logic [3:0] nibble);
         if (nibble < 4'd10) begin
            return 8'h30 + {4'd0, nibble};
         end
         return 8'h41 + {4'd0, nibble} - 8'd10;
      endfunction

      // byte after the backslash for a two-byte escape, zero when there is none
      function logic [7:0] escape_letter(logic [15:0] u);
         case (u)
            {8'h00, QuoteChar}:     return QuoteChar;
            {8'h00, BackslashChar}: return BackslashChar;
            {8'h00, SlashChar}:     return SlashChar;
            {8'h00, BackspaceChar}: return LetterB;
            {8'h00, FormfeedChar}:  return LetterF;
            {8'h00, NewlineChar}:   return LetterN;
            {8'h00, ReturnChar}:    return LetterR;
            {8'h00, TabChar}:       return LetterT;
            default:                return 8'h00;
         endcase
      endfunction

      // work out the bytes that one accepted unit yields and queue them
      function void note_unit(req_type item);
         rsp_type    burst[$];
         logic [15:0] u;
         logic [7:0]  letter;
         u = item.code_unit;
         if (item.empty_string) begin
            burst.push_back(plain_byte(QuoteChar));
            burst.push_back(plain_byte(QuoteChar));
         end else begin
            if (item.first_unit) begin
               burst.push_back(plain_byte(QuoteChar));
            end
            letter = escape_letter(u);
            if (u[15:8] != 8'h00) begin
               burst.push_back(plain_byte(BackslashChar));
               burst.push_back(plain_byte(LetterU));
               burst.push_back(plain_byte(hex_digit(u[15:12])));
               burst.push_back(plain_byte(hex_digit(u[11:8])));
               burst.push_back(plain_byte(hex_digit(u[7:4])));
               burst.push_back(plain_byte(hex_digit(u[3:0])));
            end else if (letter != 8'h00) begin
               burst.push_back(plain_byte(BackslashChar));
               burst.push_back(plain_byte(letter));
            end else if (u < {8'h00, SpaceChar} || u == {8'h00, DeleteChar}) begin
               // other control characters are dropped
            end else begin
               burst.push_back(plain_byte(u[7:0]));
            end
            if (item.last_unit) begin
               burst.push_back(plain_byte(QuoteChar));
            end
         end
         if (burst.size() > 0) begin
            burst[burst.size() - 1].last_byte = 1'b1;
         end
         foreach (burst[i]) begin
            expected_bytes.push_back(burst[i]);
         end
      endfunction

      function void report_fault(string msg);
         fault_count++;
         if (fault_count <= ReportLimit) begin
            $display("%0t: %s", $realtime, msg);
         end
      endfunction

      // compare one output transfer with the oldest expected byte
      function void check_byte(rsp_type got);
         rsp_type want;
         if (expected_bytes.size() == 0) begin
            report_fault($sformatf("unexpected byte %h last %b", got.out_byte, got.last_byte));
            return;
         end
         want = expected_bytes.pop_front();
         if (want.out_byte != got.out_byte || want.last_byte != got.last_byte) begin
            report_fault($sformatf("byte mismatch: expected %h last %b, got %h last %b",
                                   want.out_byte, want.last_byte,
                                   got.out_byte, got.last_byte));
         end
      endfunction

      function bit failed();
         return fault_count != 0 || expected_bytes.size() != 0;
      endfunction
   endclass

   logic    clock        = 1'b0;
   logic    reset        = 1'b1;
   logic    req_valid    = 1'b0;
   logic    req_stall;
   req_type req_data     = '0;
   logic    rsp_valid;
   logic    rsp_stall    = 1'b0;
   rsp_type rsp_data;

   escape_scoreboard sb = new();
   bit  calm          = 1'b0;
   int  req_gap_pct   = 0;
   int  rsp_stall_pct = 0;
   int  quiet_cycles  = 0;

   json_string_escaper_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // observe transfers on both channels and guard against a hang
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            sb.note_unit(req_data);
         end
         if (rsp_valid && !rsp_stall) begin
            sb.check_byte(rsp_data);
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= StallLimit) begin
            $display("simulation failed");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // hold the output back in random bursts, with a rate that changes now and then
   initial begin
      int stall_left;
      int cycle_count;
      stall_left  = 0;
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count % 32 == 0) begin
            case ($urandom_range(0, 2))
               0:       rsp_stall_pct = 0;
               1:       rsp_stall_pct = 15;
               default: rsp_stall_pct = 40;
            endcase
         end
         if (stall_left == 0 && !calm && $urandom_range(0, 99) < rsp_stall_pct) begin
            stall_left = $urandom_range(1, 6);
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic req_type make_unit(logic [15:0] u, logic first, logic last,
                                         logic empty);
      req_type item;
      item.code_unit    = u;
      item.first_unit   = first;
      item.last_unit    = last;
      item.empty_string = empty;
      return item;
   endfunction

   // code unit drawn from the interesting classes of character
   function automatic logic [15:0] pick_unit();
      logic [7:0] specials [8];
      specials = '{QuoteChar, BackslashChar, SlashChar, BackspaceChar,
                   FormfeedChar, NewlineChar, ReturnChar, TabChar};
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return 16'($urandom_range(32, 126));
         4:          return {8'h00, specials[$urandom_range(0, 7)]};
         5:          return ($urandom_range(0, 4) == 0) ? {8'h00, DeleteChar}
                                                        : 16'($urandom_range(0, 31));
         6:          return 16'($urandom_range(128, 255));
         7:          return 16'($urandom_range(16'hD800, 16'hDFFF));
         default:    return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // present one unit, idling first now and then, and wait for its transfer
   task automatic send_unit(req_type item);
      if (!calm && $urandom_range(0, 99) < req_gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do begin
         @(posedge clock);
      end while (req_stall);
   endtask

   // one JSON string of random length, sometimes with a mark missing
   task automatic send_string(output int sent);
      int  length;
      bit  drop_first;
      bit  drop_last;
      length     = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 8);
      drop_first = ($urandom_range(0, 9) == 0);
      drop_last  = ($urandom_range(0, 9) == 0);
      sent       = 0;
      if (length == 0) begin
         send_unit(make_unit(16'($urandom_range(0, 65535)), 1'($urandom),
                             1'($urandom), 1'b1));
         sent = 1;
      end else begin
         for (int i = 0; i < length; i++) begin
            send_unit(make_unit(pick_unit(), i == 0 && !drop_first,
                                i == length - 1 && !drop_last, 1'b0));
            sent++;
         end
      end
   endtask

   initial begin
      int random_sent;
      int burst;
      random_sent = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: empty strings, plain bytes, short escapes, drops, hex escapes
      send_unit(make_unit(16'hFFFF, 1'b1, 1'b1, 1'b1));
      send_unit(make_unit(16'h0000, 1'b0, 1'b0, 1'b1));
      send_unit(make_unit(16'h0041, 1'b1, 1'b0, 1'b0));
      send_unit(make_unit({8'h00, SpaceChar}, 1'b0, 1'b0, 1'b0));
      send_unit(make_unit({8'h00, QuoteChar}, 1'b0, 1'b0, 1'b0));
      send_unit(make_unit({8'h00, BackslashChar}, 1'b0, 1'b0, 1'b0));
      send_unit(make_unit({8'h00, SlashChar}, 1'b0, 1'b0, 1'b0));
      send_unit(make_unit({8'h00, BackspaceChar}, 1'b0, 1'b0, 1'b0));
      send_unit(make_unit({8'h00, FormfeedChar}, 1'b0, 1'b0, 1'b0));
      send_unit(make_unit({8'h00, NewlineChar}, 1'b0, 1'b0, 1'b0));
      send_unit(make_unit({8'h00, ReturnChar}, 1'b0, 1'b0, 1'b0));
      send_unit(make_unit({8'h00, TabChar}, 1'b0, 1'b1, 1'b0));
      send_unit(make_unit({8'h00, DeleteChar}, 1'b0, 1'b0, 1'b0));
      send_unit(make_unit(16'h0000, 1'b1, 1'b0, 1'b0));
      send_unit(make_unit(16'h001F, 1'b0, 1'b1, 1'b0));
      send_unit(make_unit(16'h007E, 1'b1, 1'b0, 1'b0));
      send_unit(make_unit(16'h0080, 1'b0, 1'b0, 1'b0));
      send_unit(make_unit(16'h00FF, 1'b0, 1'b1, 1'b0));
      send_unit(make_unit(16'h0100, 1'b1, 1'b0, 1'b0));
      send_unit(make_unit(16'hD800, 1'b0, 1'b0, 1'b0));
      send_unit(make_unit(16'hDFFF, 1'b0, 1'b0, 1'b0));
      send_unit(make_unit(16'hABCD, 1'b0, 1'b1, 1'b0));
      send_unit(make_unit(16'hFFFF, 1'b1, 1'b1, 1'b0));
      // marks out of order
      send_unit(make_unit(16'h0042, 1'b0, 1'b1, 1'b0));
      send_unit(make_unit(16'h0043, 1'b1, 1'b0, 1'b0));
      send_unit(make_unit(16'h0044, 1'b1, 1'b1, 1'b0));

      // random: mostly well-formed strings, some raw noise
      while (random_sent < RandomUnits) begin
         calm = (random_sent >= CalmUnits);
         case ($urandom_range(0, 2))
            0:       req_gap_pct = 0;
            1:       req_gap_pct = 15;
            default: req_gap_pct = 40;
         endcase
         if ($urandom_range(0, 9) == 0) begin
            send_unit(req_type'($urandom));
            random_sent++;
         end else begin
            send_string(burst);
            random_sent += burst;
         end
      end
      req_valid <= 1'b0;

      // drain, then allow for anything stray
      while (sb.expected_bytes.size() != 0) begin
         @(posedge clock);
      end
      repeat (DrainCycles) @(posedge clock);

      if (sb.failed()) begin
         $display("simulation failed");
      end else begin
         $display("simulation ok");
      end
      $finish;
   end

endmodule
